### rtl/core/m4mul_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m4mul_pkg
// shared constants and types of the fixed-point matrix multiply core
// ----------------------------------------------------------------------------
package m4mul_pkg;

	localparam int OP_W   = 2;
	localparam int IDX_W  = 4;
	localparam int VAL_W  = 32;
	localparam int DATA_W = 40;

	localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
	localparam logic [OP_W-1:0] OP_MULTIPLY   = 2'd2;

	// tag that travels with one product through the multiply-accumulate path
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last_k;
		logic             last_elem;
		logic [IDX_W-1:0] index;
	} m4mul_tag_t;

endpackage
`default_nettype wire

### rtl/core/m4mul_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m4mul_mac
// registered signed multiply, scaled accumulate and 32-bit saturation
// ----------------------------------------------------------------------------
module m4mul_mac #(
	parameter int FRAC_BITS = 16,
	parameter int DIM       = 4
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire logic signed [m4mul_pkg::VAL_W-1:0] op_a,
	input  wire logic signed [m4mul_pkg::VAL_W-1:0] op_b,
	input  wire m4mul_pkg::m4mul_tag_t       tag,
	output logic                             res_vld,
	output logic [m4mul_pkg::VAL_W-1:0]      res_value,
	output logic [m4mul_pkg::IDX_W-1:0]      res_index,
	output logic                             res_last
);
	import m4mul_pkg::*;

	localparam int ACC_W = 2 * VAL_W - FRAC_BITS + $clog2(DIM) + 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7fffffff);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(32'sh80000000);

	logic signed [2*VAL_W-1:0] prod_s2;
	m4mul_tag_t                tag_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   prod_sh;
	logic signed [ACC_W-1:0]   acc_base;
	logic signed [ACC_W-1:0]   acc_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= op_a * op_b;
		if (tag_s2.vld) begin
			acc_q <= acc_sum;
		end
	end

	// floor scaling of the exact product
	assign prod_sh  = ACC_W'(prod_s2 >>> FRAC_BITS);
	assign acc_base = tag_s2.first ? '0 : acc_q;
	assign acc_sum  = acc_base + prod_sh;

	always_comb begin
		priority if (acc_sum > SAT_HI) begin
			res_value = 32'h7fffffff;
		end else if (acc_sum < SAT_LO) begin
			res_value = 32'h80000000;
		end else begin
			res_value = acc_sum[VAL_W-1:0];
		end
	end

	assign res_vld   = tag_s2.vld & tag_s2.last_k;
	assign res_index = tag_s2.index;
	assign res_last  = tag_s2.last_elem;

endmodule
`default_nettype wire

### rtl/core/matrix4_multiply_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_multiply_core
// column-major DIM x DIM signed fixed-point matrix product over two operand
// memories, while terms issue one multiply-accumulate per cycle
// ----------------------------------------------------------------------------
// a multiply walks the start, issue and drain states for each result element;
// each term passes the operand read register, the product register and the
// accumulator into the output register; the element rate is set by the single
// multiply-accumulate unit and the one-deep output register
// the next transaction is accepted once the final element sits in the output
// reset: asynchronous, both matrices read as zero until written
module matrix4_multiply_core #(
	parameter int FRAC_BITS = 16,
	parameter int DIM       = 4
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// element_index[3:0], element_value[35:4], zero fill
	input  wire  [m4mul_pkg::DATA_W-1:0]      s_axis_tdata,
	// op[1:0]
	input  wire  [m4mul_pkg::OP_W-1:0]        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// result_index[3:0], result_value[35:4], zero fill
	output logic [m4mul_pkg::DATA_W-1:0]      m_axis_tdata,
	output logic                              m_axis_tlast
);
	import m4mul_pkg::*;

	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);
	localparam int DW    = $clog2(DIM);
	localparam logic [AW-1:0] DIM_A  = AW'(DIM);
	localparam logic [AW-1:0] E_LAST = AW'(CELLS - 1);
	localparam logic [DW-1:0] K_LAST = DW'(DIM - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]       state_q;
	logic [AW-1:0]    elem_q;
	logic [DW-1:0]    row_q;
	logic [DW-1:0]    k_q;
	logic [AW-1:0]    col_base_q;
	logic [AW-1:0]    laddr_q;
	logic [AW-1:0]    raddr_q;
	logic [CELLS-1:0] left_vld_q;
	logic [CELLS-1:0] right_vld_q;

	logic [VAL_W-1:0] left_mem  [CELLS];
	logic [VAL_W-1:0] right_mem [CELLS];

	logic [VAL_W-1:0] left_rd_s1;
	logic [VAL_W-1:0] right_rd_s1;
	logic             left_ok_s1;
	logic             right_ok_s1;
	m4mul_tag_t       tag_s1;
	m4mul_tag_t       tag_nxt;

	logic [OP_W-1:0]  in_op;
	logic [IDX_W-1:0] in_idx;
	logic [VAL_W-1:0] in_val;
	logic             in_acc;
	logic             idx_ok;
	logic [AW-1:0]    wr_addr;
	logic             wr_left;
	logic             wr_right;

	logic signed [VAL_W-1:0] op_a;
	logic signed [VAL_W-1:0] op_b;
	logic                    res_vld;
	logic [VAL_W-1:0]        res_value;
	logic [IDX_W-1:0]        res_index;
	logic                    res_last;

	logic             out_vld_q;
	logic [VAL_W-1:0] out_value_q;
	logic [IDX_W-1:0] out_index_q;
	logic             out_last_q;

	assign in_op   = s_axis_tuser;
	assign in_idx  = s_axis_tdata[IDX_W-1:0];
	assign in_val  = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc  = s_axis_tvalid & s_axis_tready;
	assign idx_ok  = ({3'b000, in_idx} < 7'(CELLS));
	assign wr_addr = AW'(in_idx);
	assign wr_left  = in_acc & idx_ok & (in_op == OP_LOAD_LEFT);
	assign wr_right = in_acc & idx_ok & (in_op == OP_LOAD_RIGHT);

	// operand memories
	always_ff @(posedge clk) begin
		if (wr_left) begin
			left_mem[wr_addr] <= in_val;
		end
		if (wr_right) begin
			right_mem[wr_addr] <= in_val;
		end
		left_rd_s1  <= left_mem[laddr_q];
		right_rd_s1 <= right_mem[raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_vld_q  <= '0;
			right_vld_q <= '0;
			left_ok_s1  <= 1'b0;
			right_ok_s1 <= 1'b0;
			tag_s1      <= '0;
		end else begin
			if (wr_left) begin
				left_vld_q[wr_addr] <= 1'b1;
			end
			if (wr_right) begin
				right_vld_q[wr_addr] <= 1'b1;
			end
			left_ok_s1  <= left_vld_q[laddr_q];
			right_ok_s1 <= right_vld_q[raddr_q];
			tag_s1      <= tag_nxt;
		end
	end

	always_comb begin
		tag_nxt           = '0;
		tag_nxt.vld       = (state_q == ST_ISSUE);
		tag_nxt.first     = (k_q == '0);
		tag_nxt.last_k    = (k_q == K_LAST);
		tag_nxt.last_elem = (elem_q == E_LAST);
		tag_nxt.index     = IDX_W'(elem_q);
	end

	// sequencer over result elements and inner-product terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			elem_q     <= '0;
			row_q      <= '0;
			k_q        <= '0;
			col_base_q <= '0;
			laddr_q    <= '0;
			raddr_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_op == OP_MULTIPLY) begin
						state_q    <= ST_START;
						elem_q     <= '0;
						row_q      <= '0;
						k_q        <= '0;
						col_base_q <= '0;
						laddr_q    <= '0;
						raddr_q    <= '0;
					end
				end
				ST_START: begin
					if (!out_vld_q) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					laddr_q <= laddr_q + DIM_A;
					raddr_q <= raddr_q + AW'(1);
					if (k_q == K_LAST) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + DW'(1);
					end
				end
				ST_DRAIN: begin
					if (res_vld) begin
						if (elem_q == E_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_START;
							elem_q  <= elem_q + AW'(1);
							if (row_q == K_LAST) begin
								row_q      <= '0;
								col_base_q <= col_base_q + DIM_A;
								laddr_q    <= '0;
								raddr_q    <= col_base_q + DIM_A;
							end else begin
								row_q   <= row_q + DW'(1);
								laddr_q <= AW'(row_q) + AW'(1);
								raddr_q <= col_base_q;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// entries never written read as zero
	assign op_a = left_ok_s1  ? signed'(left_rd_s1)  : '0;
	assign op_b = right_ok_s1 ? signed'(right_rd_s1) : '0;

	m4mul_mac #(
		.FRAC_BITS (FRAC_BITS),
		.DIM       (DIM)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_a      (op_a),
		.op_b      (op_b),
		.tag       (tag_s1),
		.res_vld   (res_vld),
		.res_value (res_value),
		.res_index (res_index),
		.res_last  (res_last)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_vld) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			out_value_q <= res_value;
			out_index_q <= res_index;
			out_last_q  <= res_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(DATA_W-VAL_W-IDX_W){1'b0}}, out_value_q, out_index_q};
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

### dv/matrix4_multiply_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_multiply_core_tb
// self-checking bench for the 4x4 fixed-point matrix product core: loads and
// multiplies stream in under random idling, a local Q16.16 predictor queues
// the sixteen product elements per multiply, and every output transaction
// is compared field by field against the oldest queued element
// ----------------------------------------------------------------------------
module matrix4_multiply_core_tb;

	import m4mul_pkg::*;

	localparam int FRAC  = 16;
	localparam int N     = 4;
	localparam int CELLS = N * N;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
	} mat_item_t;

	typedef struct {
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             last;
	} product_elem_t;

	logic clk;
	logic arst_n = 1'b0;

	logic              s_tvalid = 1'b0;
	wire               s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;
	logic [OP_W-1:0]   s_tuser  = '0;
	wire               m_tvalid;
	logic              m_tready = 1'b0;
	wire  [DATA_W-1:0] m_tdata;
	wire               m_tlast;

	mat_item_t     op_queue[$];
	product_elem_t product_q[$];

	logic signed [VAL_W-1:0] left_m  [CELLS];
	logic signed [VAL_W-1:0] right_m [CELLS];

	int send_idle_pct = 20;
	int recv_idle_pct = 47;
	int fail_count    = 0;
	int results_seen  = 0;
	int hold_left     = 0;
	bit hold_used     = 1'b0;

	matrix4_multiply_core #(
		.FRAC_BITS(FRAC),
		.DIM      (N)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata),
		.m_axis_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// floor-shifted products summed wide, then clamped to 32 bits
	function automatic logic [VAL_W-1:0] dot_product_sat(int row, int col);
		longint acc;
		longint p;
		acc = 0;
		for (int k = 0; k < N; k++) begin
			p = longint'(left_m[row + N*k]) * longint'(right_m[k + N*col]);
			acc += p >>> FRAC;
		end
		if (acc > SAT_HI)
			return 32'h7FFF_FFFF;
		if (acc < SAT_LO)
			return 32'h8000_0000;
		return acc[31:0];
	endfunction

	task automatic apply_matrix_op(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		product_elem_t e;
		case (op)
			OP_LOAD_LEFT: begin
				if (idx < CELLS)
					left_m[idx] = val;
			end
			OP_LOAD_RIGHT: begin
				if (idx < CELLS)
					right_m[idx] = val;
			end
			OP_MULTIPLY: begin
				for (int i = 0; i < CELLS; i++) begin
					e.index = i[IDX_W-1:0];
					e.value = dot_product_sat(i % N, i / N);
					e.last  = (i == CELLS - 1);
					product_q.push_back(e);
				end
			end
			default: ;
		endcase
	endtask

	// sender: next item only once the current one is taken
	always @(posedge clk or negedge arst_n) begin : driver
		mat_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				apply_matrix_op(s_tuser, s_tdata[IDX_W-1:0], s_tdata[IDX_W +: VAL_W]);
			if (!s_tvalid || s_tready) begin
				if (op_queue.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
					nxt = op_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= nxt.op;
					s_tdata  <= {{(DATA_W-IDX_W-VAL_W){1'b0}}, nxt.value, nxt.index};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off mid-multiply
	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (!hold_used && results_seen >= 40) begin
			hold_used <= 1'b1;
			hold_left <= 300;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(1, 100) > recv_idle_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		product_elem_t e;
		logic [IDX_W-1:0] got_idx;
		logic [VAL_W-1:0] got_val;
		if (!arst_n) begin
			results_seen <= 0;
		end else if (m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			got_idx = m_tdata[IDX_W-1:0];
			got_val = m_tdata[IDX_W +: VAL_W];
			if (product_q.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected transaction: idx %0d val %h last %b",
						got_idx, got_val, m_tlast);
				fail_count++;
			end else begin
				e = product_q.pop_front();
				if (got_idx !== e.index || got_val !== e.value || m_tlast !== e.last) begin
					if (fail_count < 10)
						$display("mismatch at result %0d: exp idx %0d val %h last %b, got idx %0d val %h last %b",
							results_seen, e.index, e.value, e.last, got_idx, got_val, m_tlast);
					fail_count++;
				end
			end
		end
	end

	task automatic queue_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		mat_item_t it;
		it.op    = op;
		it.index = idx;
		it.value = val;
		op_queue.push_back(it);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					4: return 32'h0001_0000;
					default: return 32'hFFFF_0000;
				endcase
			end
			1, 2, 3: return $urandom;
			// within about +/- 4.0 so sums mostly stay in range
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	// checked away from the rising edge so every update of that edge has settled
	task automatic wait_drained();
		while (op_queue.size() != 0 || s_tvalid || product_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_random_phase(input int count);
		int pushed;
		int n;
		pushed = 0;
		while (pushed < count) begin
			n = $urandom_range(1, 24);
			for (int j = 0; j < n; j++) begin
				if ($urandom_range(0, 19) == 0) begin
					queue_item(OP_UNUSED, IDX_W'($urandom_range(0, 15)), $urandom);
				end else begin
					queue_item($urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT,
						IDX_W'($urandom_range(0, 15)), pick_value());
					pushed++;
				end
			end
			queue_item(OP_MULTIPLY, IDX_W'($urandom_range(0, 15)), $urandom);
			pushed++;
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			left_m[i]  = '0;
			right_m[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// product of the cleared stores
		queue_item(OP_MULTIPLY, 4'd0, 32'h0);
		// saturation high, saturation low, floor of a negative product
		queue_item(OP_LOAD_LEFT,  4'd0,  32'h7FFF_FFFF);
		queue_item(OP_LOAD_RIGHT, 4'd0,  32'h7FFF_FFFF);
		queue_item(OP_LOAD_LEFT,  4'd15, 32'h8000_0000);
		queue_item(OP_LOAD_RIGHT, 4'd15, 32'h8000_0000);
		queue_item(OP_LOAD_LEFT,  4'd1,  32'h8000_0000);
		queue_item(OP_LOAD_LEFT,  4'd2,  32'hFFFF_FFFF);
		queue_item(OP_LOAD_RIGHT, 4'd8,  32'h0000_0001);
		queue_item(OP_LOAD_RIGHT, 4'd5,  32'h0001_0000);
		queue_item(OP_LOAD_LEFT,  4'd5,  32'hFFFF_0000);
		queue_item(OP_UNUSED,     4'd15, 32'hFFFF_FFFF);
		queue_item(OP_UNUSED,     4'd0,  32'h0000_0000);
		queue_item(OP_MULTIPLY,   4'd15, 32'hFFFF_FFFF);
		// 1.0 on the diagonal of the right matrix
		for (int i = 0; i < N; i++)
			queue_item(OP_LOAD_RIGHT, IDX_W'(i * (N + 1)), 32'h0001_0000);
		queue_item(OP_LOAD_RIGHT, 4'd15, 32'h0001_0000);
		queue_item(OP_LOAD_RIGHT, 4'd0,  32'h0001_0000);
		queue_item(OP_MULTIPLY,   4'd0,  32'h0);
		wait_drained();

		queue_random_phase(150);
		wait_drained();

		send_idle_pct = 47;
		recv_idle_pct = 20;
		queue_random_phase(150);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_phase(150);
		wait_drained();

		repeat (64) @(posedge clk);
		if (fail_count == 0 && product_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout");
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
